// ----- hw/rtl/sopm_pkg.sv -----
`timescale 1ns / 1ps

package sopm_pkg;

	localparam int DELAY_W = 24;
	localparam int COUNT_W = 8;
	localparam int ID_W    = 16;
	localparam int KIND_W  = 2;
	localparam int REQ_W   = 2;
	localparam int CFG_IDX_W = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STATUS = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

	// send kinds
	localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MULTI   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNI     = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WAIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC_DELAY = 2'd3;

	localparam logic [ID_W-1:0] ANY_ID = 16'hFFFF;

	// result queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;

	typedef struct packed {
		logic [DELAY_W-1:0] initial_wait;
		logic [DELAY_W-1:0] repeat_delay;
		logic [COUNT_W-1:0] repeat_limit;
		logic [DELAY_W-1:0] cyclic_delay;
	} sopm_cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] send_kind;
		logic [ID_W-1:0]   out_service;
		logic [ID_W-1:0]   out_instance;
		logic [ID_W-1:0]   out_target;
		logic              last_send;
	} sopm_send_t;

	// up to two sends produced by one request
	typedef struct packed {
		logic       v0;
		logic       v1;
		sopm_send_t d0;
		sopm_send_t d1;
	} sopm_push_t;

	function automatic sopm_send_t bcast_send(input logic [KIND_W-1:0] kind);
		sopm_send_t s;
		s.send_kind    = kind;
		s.out_service  = ANY_ID;
		s.out_instance = ANY_ID;
		s.out_target   = '0;
		s.last_send    = 1'b0;
		return s;
	endfunction

endpackage

// ----- hw/rtl/sopm_req_if.sv -----
`timescale 1ns / 1ps

interface sopm_req_if;
	import sopm_pkg::*;

	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic               net_ready;
	logic               group_started;
	logic               unicast_ok;
	logic [ID_W-1:0]    req_service;
	logic [ID_W-1:0]    req_instance;
	logic [ID_W-1:0]    requester;

	modport source (
		output valid, req_type, net_ready, group_started, unicast_ok,
		output req_service, req_instance, requester,
		input  ready
	);

	modport sink (
		input  valid, req_type, net_ready, group_started, unicast_ok,
		input  req_service, req_instance, requester,
		output ready
	);
endinterface

// ----- hw/rtl/sopm_send_if.sv -----
`timescale 1ns / 1ps

interface sopm_send_if;
	import sopm_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] send_kind;
	logic [ID_W-1:0]   out_service;
	logic [ID_W-1:0]   out_instance;
	logic [ID_W-1:0]   out_target;
	logic              last_send;

	modport source (
		output valid, send_kind, out_service, out_instance, out_target, last_send,
		input  ready
	);

	modport sink (
		input  valid, send_kind, out_service, out_instance, out_target, last_send,
		output ready
	);
endinterface

// ----- hw/rtl/service_offer_phase_machine.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// --------  ---  ------------------------------------------------------------
// req       in   req_type, net_ready, group_started, unicast_ok,
//                req_service, req_instance, requester
// send      out  send_kind, out_service, out_instance, out_target, last_send
// cfg_*     in   write-only register port: cfg_we, cfg_index, cfg_data
//
// A req beat lands in the input stage, is evaluated and pushed into a
// four-entry send queue; send beats go out from the head of that queue.
// One req beat per cycle is taken as long as each request makes at most
// one send and the send port keeps up; the sustained rate is set by the
// send port, one send beat per cycle. The input stage holds when fewer
// than two queue slots are free.
// arst_n clears phase (inactive), timer, repeat count, queue and registers.

module service_offer_phase_machine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sopm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sopm_pkg::DELAY_W-1:0]    cfg_data,
	sopm_req_if.sink                        req,
	sopm_send_if.source                     send
);
	import sopm_pkg::*;

	sopm_cfg_t  cfg_q;
	sopm_push_t push;
	logic       room;

	// config is only to be written while the block is idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INITIAL_WAIT: cfg_q.initial_wait <= cfg_data;
				CFG_REPEAT_DELAY: cfg_q.repeat_delay <= cfg_data;
				CFG_REPEAT_LIMIT: cfg_q.repeat_limit <= cfg_data[COUNT_W-1:0];
				CFG_CYCLIC_DELAY: cfg_q.cyclic_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	// phase machine and timer
	sopm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.room   (room),
		.req    (req),
		.push   (push)
	);

	// send queue, takes up to two sends per cycle
	sopm_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.send   (send)
	);

`ifndef SYNTHESIS
	// second send only ever follows a first
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second send without first");

	// core pushes only when the queue has two free slots
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> room)
		else $error("send pushed into full queue");

	// exactly the final send of a request carries last_send
	a_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && push.v1) |-> (push.d1.last_send && !push.d0.last_send))
		else $error("last_send misplaced on two-send request");

	a_push_single: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && !push.v1) |-> push.d0.last_send)
		else $error("single send lacks last_send");
`endif

endmodule

// ----- hw/rtl/sopm_core.sv -----
`timescale 1ns / 1ps

module sopm_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sopm_pkg::sopm_cfg_t    cfg,
	input  logic                   room,
	sopm_req_if.sink               req,
	output sopm_pkg::sopm_push_t   push
);
	import sopm_pkg::*;

	typedef enum logic [1:0] {
		PH_INACTIVE,
		PH_INITIAL,
		PH_REPEAT,
		PH_ANNOUNCE
	} phase_t;

	// input stage
	logic               valid_s1;
	logic [REQ_W-1:0]   type_s1;
	logic               up_s1;
	logic               uni_s1;
	logic [ID_W-1:0]    svc_s1;
	logic [ID_W-1:0]    inst_s1;
	logic [ID_W-1:0]    who_s1;

	// phase machine state
	phase_t             phase_q, phase_n;
	logic [COUNT_W-1:0] rcount_q, rcount_n;
	logic [DELAY_W-1:0] time_q, time_n;
	logic               run_q, run_n;

	logic       advance;
	logic       take;
	logic       pre_v;
	sopm_send_t pre_d;
	logic       enter_rep;
	logic       enter_ann;
	sopm_send_t ent_d;

	assign advance   = valid_s1 & room;
	assign req.ready = ~valid_s1 | room;
	assign take      = req.valid & req.ready;

	always_comb begin
		phase_n   = phase_q;
		rcount_n  = rcount_q;
		time_n    = time_q;
		run_n     = run_q;
		pre_v     = 1'b0;
		pre_d     = bcast_send(KIND_DEFAULT);
		enter_rep = 1'b0;
		enter_ann = 1'b0;

		case (type_s1)
			REQ_TICK: begin
				if (run_q) begin
					if (time_q <= DELAY_W'(1)) begin
						time_n = '0;
						run_n  = 1'b0;
						case (phase_q)
							PH_INITIAL: begin
								if (cfg.repeat_limit != '0) enter_rep = 1'b1;
								else enter_ann = 1'b1;
							end
							PH_REPEAT: begin
								if (rcount_q == cfg.repeat_limit) begin
									enter_ann = 1'b1;
								end else begin
									rcount_n  = rcount_q + COUNT_W'(1);
									enter_rep = 1'b1;
								end
							end
							PH_ANNOUNCE: enter_ann = 1'b1;
							default: ;
						endcase
					end else begin
						time_n = time_q - DELAY_W'(1);
					end
				end
			end
			REQ_STATUS: begin
				if (phase_q == PH_INACTIVE) begin
					if (up_s1) begin
						phase_n = PH_INITIAL;
						time_n  = cfg.initial_wait;
						run_n   = 1'b1;
					end
				end else if (!up_s1) begin
					run_n    = 1'b0;
					time_n   = '0;
					pre_v    = 1'b1;
					phase_n  = PH_INACTIVE;
					rcount_n = '0;
				end
			end
			REQ_FIND: begin
				if (phase_q == PH_REPEAT) begin
					pre_v     = 1'b1;
					enter_rep = 1'b1;
				end else if (phase_q == PH_ANNOUNCE) begin
					pre_v = 1'b1;
					// unicast only while more than half the cycle remains
					if (uni_s1 && (time_q > {1'b0, cfg.cyclic_delay[DELAY_W-1:1]})) begin
						pre_d.send_kind    = KIND_UNI;
						pre_d.out_service  = svc_s1;
						pre_d.out_instance = inst_s1;
						pre_d.out_target   = who_s1;
					end else begin
						pre_d = bcast_send(KIND_MULTI);
					end
					enter_ann = 1'b1;
				end
			end
			default: ;
		endcase

		ent_d = bcast_send(enter_ann ? KIND_MULTI : KIND_DEFAULT);
		if (enter_rep) begin
			phase_n = PH_REPEAT;
			time_n  = cfg.repeat_delay;
			run_n   = 1'b1;
		end else if (enter_ann) begin
			phase_n = PH_ANNOUNCE;
			time_n  = cfg.cyclic_delay;
			run_n   = 1'b1;
		end

		push = '0;
		if (advance) begin
			if (pre_v) begin
				push.v0 = 1'b1;
				push.d0 = pre_d;
				push.v1 = enter_rep | enter_ann;
				push.d1 = ent_d;
				push.d0.last_send = ~(enter_rep | enter_ann);
				push.d1.last_send = 1'b1;
			end else begin
				push.v0 = enter_rep | enter_ann;
				push.d0 = ent_d;
				push.d0.last_send = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_INACTIVE;
			rcount_q <= '0;
			time_q   <= '0;
			run_q    <= 1'b0;
		end else begin
			if (req.ready) valid_s1 <= req.valid;
			if (advance) begin
				phase_q  <= phase_n;
				rcount_q <= rcount_n;
				time_q   <= time_n;
				run_q    <= run_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			type_s1 <= req.req_type;
			up_s1   <= req.net_ready & req.group_started;
			uni_s1  <= req.unicast_ok;
			svc_s1  <= req.req_service;
			inst_s1 <= req.req_instance;
			who_s1  <= req.requester;
		end
	end

endmodule

// ----- hw/rtl/sopm_outq.sv -----
`timescale 1ns / 1ps

module sopm_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sopm_pkg::sopm_push_t push,
	output logic                 room,
	sopm_send_if.source          send
);
	import sopm_pkg::*;

	sopm_send_t           mem [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_q;
	logic [OUTQ_AW-1:0]   rd_q;
	logic [OUTQ_AW:0]     cnt_q;
	logic [1:0]           n_push;
	logic                 pop;
	sopm_send_t           head;

	assign n_push = {1'b0, push.v0} + {1'b0, push.v1};
	// two free slots needed, one request can make two sends
	assign room   = cnt_q <= (OUTQ_AW + 1)'(OUTQ_DEPTH - 2);
	assign pop    = send.valid & send.ready;

	assign head              = mem[rd_q];
	assign send.valid        = cnt_q != '0;
	assign send.send_kind    = head.send_kind;
	assign send.out_service  = head.out_service;
	assign send.out_instance = head.out_instance;
	assign send.out_target   = head.out_target;
	assign send.last_send    = head.last_send;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OUTQ_AW'(n_push);
			rd_q  <= rd_q + OUTQ_AW'(pop);
			cnt_q <= cnt_q + (OUTQ_AW + 1)'(n_push) - (OUTQ_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.v0) mem[wr_q] <= push.d0;
		if (push.v1) mem[wr_q + OUTQ_AW'(1)] <= push.d1;
	end

endmodule
